// File: sv/bfpq_pkg.sv
// bfpq_pkg: shared types and constants for the bilateral filter pixel query block
package bfpq_pkg;
   localparam int RADIUS_DEF   = 6;
   localparam int MAX_SIDE_DEF = 128;
   localparam int RANGE_DEPTH  = 256;

   typedef enum logic [1:0] {
      OP_WR_PIXEL   = 2'd0,
      OP_WR_SPATIAL = 2'd1,
      OP_WR_RANGE   = 2'd2,
      OP_QUERY      = 2'd3
   } opcode_type;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [6:0]  coord_x;
      logic [6:0]  coord_y;
      logic [7:0]  table_index;
      logic [7:0]  pixel_value;
      logic [15:0] weight_value;
   } req_type;

   typedef struct packed {
      logic [7:0] filtered_pixel;
      logic       status;
   } rsp_type;
endpackage

// File: sv/bfpq_ram.sv
// bfpq_ram: generic single-port-write ram with registered read
module bfpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: sv/bfpq_div.sv
// bfpq_div: restoring divider, one quotient bit per cycle
module bfpq_div #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W+1:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = '0;
      if (start) begin
         q_in = numer;
         r_in = '0;
         d_in = denom;
         cnt_in = CW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {r_ff, q_ff[NUM_W-1]} - {2'b00, d_ff};
         if (!trial[DEN_W+1]) begin
            r_in = trial[DEN_W:0];
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

// File: sv/bilateral_filter_pixel_query.sv
// bilateral_filter_pixel_query: top level of the bilateral filter pixel query block
//
// Usage: items arrive on req_ (valid/ready) as bfpq_pkg::req_type beats.
// Opcodes 0..2 write a pixel, a spatial weight or a range weight; they give no
// response beat and pass through S_WRITE back to idle. Opcode 3 queries one
// filtered pixel and gives one rsp_ beat (bfpq_pkg::rsp_type).
// A query walks the (2*RADIUS+1)^2 window one neighbor at a time: each
// neighbor passes in order through the single pixel ram port and single
// multiplier (pixel read, read wait, weight reads, product, accumulate);
// the restoring divider then gives one quotient bit per cycle.
// Out-of-image queries answer from S_CREAD and queries on row or column 0
// from S_CWAIT, without the window walk.
// One item is in flight at a time; req_ready is low until its response is
// taken. If the receiver stalls, rsp_valid holds with the beat unchanged.
// Reset (synchronous, active high) returns the sequencer to idle and sets
// width and height to 128; the rams are not cleared and must be written
// before they are read. csr_ writes take effect at once and are meant only
// while the block is idle.
module bilateral_filter_pixel_query #(
   parameter int RADIUS   = bfpq_pkg::RADIUS_DEF,
   parameter int MAX_SIDE = bfpq_pkg::MAX_SIDE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bfpq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bfpq_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata
);
   import bfpq_pkg::*;

   localparam int WIN    = 2 * RADIUS + 1;
   localparam int SDEPTH = WIN * WIN;
   localparam int SAW    = $clog2(SDEPTH);
   localparam int SIDEW  = $clog2(MAX_SIDE);
   localparam int PDEPTH = MAX_SIDE * MAX_SIDE;
   localparam int PAW    = 2 * SIDEW;
   localparam int WW     = $clog2(WIN);
   localparam int TOT_W  = 17 + SAW;
   localparam int SUM_W  = TOT_W + 8;
   localparam int CRW    = $clog2(MAX_SIDE + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_WRITE, S_CREAD, S_CWAIT, S_NREAD, S_NWAIT, S_WREAD, S_MUL,
      S_ACC, S_DIV, S_DIVWAIT, S_RESP
   } state_type;

   state_type        state_ff;
   req_type          req_ff;
   rsp_type          rsp_ff;
   logic [7:0]       width_ff, height_ff;
   logic [WW-1:0]    i_ff, j_ff;
   logic [7:0]       center_ff, pix_ff;
   logic [31:0]      prod_ff;
   logic [TOT_W-1:0] total_ff;
   logic [SUM_W-1:0] sum_ff;
   logic             skip_ff;

   logic [CRW-1:0]   eff_w, eff_h;
   logic             ok_in;

   logic             p_we, s_we, r_we;
   logic [PAW-1:0]   p_waddr, p_raddr;
   logic [7:0]       p_rdata;
   logic [SAW-1:0]   s_raddr;
   logic [15:0]      s_rdata, r_rdata;
   logic [7:0]       r_raddr, diff;

   logic             div_start, div_done;
   logic [SUM_W-1:0] div_q;

   // neighbor coordinates: m = x + i - R, n = y + j - R
   logic signed [SIDEW+2:0] m_s, n_s;
   logic                    nb_in;

   assign eff_w = (int'(width_ff) > MAX_SIDE) ? CRW'(MAX_SIDE) : CRW'(width_ff);
   assign eff_h = (int'(height_ff) > MAX_SIDE) ? CRW'(MAX_SIDE) : CRW'(height_ff);
   assign ok_in = (int'(req_ff.coord_x) < int'(eff_w)) && (int'(req_ff.coord_y) < int'(eff_h));

   assign m_s = (SIDEW+3)'(req_ff.coord_x) + (SIDEW+3)'(i_ff) - (SIDEW+3)'(RADIUS);
   assign n_s = (SIDEW+3)'(req_ff.coord_y) + (SIDEW+3)'(j_ff) - (SIDEW+3)'(RADIUS);
   assign nb_in = !m_s[SIDEW+2] && !n_s[SIDEW+2]
                  && ((SIDEW+3)'(m_s) < (SIDEW+3)'(eff_w))
                  && ((SIDEW+3)'(n_s) < (SIDEW+3)'(eff_h));

   // spatial index uses dx = x - m = R - i, so entry (WIN-1-i)*WIN + (WIN-1-j)
   assign s_raddr = SAW'((WIN - 1 - int'(i_ff)) * WIN + (WIN - 1 - int'(j_ff)));
   assign diff = (pix_ff > center_ff) ? pix_ff - center_ff : center_ff - pix_ff;
   assign r_raddr = diff;

   always_comb begin
      p_raddr = {SIDEW'(req_ff.coord_y), SIDEW'(req_ff.coord_x)};
      if (state_ff == S_NREAD) begin
         p_raddr = {SIDEW'(n_s), SIDEW'(m_s)};
      end
   end

   assign p_waddr = {SIDEW'(req_ff.coord_y), SIDEW'(req_ff.coord_x)};
   assign p_we = (state_ff == S_WRITE) && (req_ff.opcode == OP_WR_PIXEL)
                 && (int'(req_ff.coord_x) < MAX_SIDE) && (int'(req_ff.coord_y) < MAX_SIDE);
   assign s_we = (state_ff == S_WRITE) && (req_ff.opcode == OP_WR_SPATIAL)
                 && (int'(req_ff.table_index) < SDEPTH);
   assign r_we = (state_ff == S_WRITE) && (req_ff.opcode == OP_WR_RANGE);
   assign div_start = (state_ff == S_DIV);

   bfpq_ram #(.WIDTH(8), .DEPTH(PDEPTH)) u_pix (
      .clock, .wr_en(p_we), .wr_addr(p_waddr), .wr_data(req_ff.pixel_value),
      .rd_addr(p_raddr), .rd_data(p_rdata)
   );
   bfpq_ram #(.WIDTH(16), .DEPTH(SDEPTH)) u_spat (
      .clock, .wr_en(s_we), .wr_addr(SAW'(req_ff.table_index)),
      .wr_data(req_ff.weight_value), .rd_addr(s_raddr), .rd_data(s_rdata)
   );
   bfpq_ram #(.WIDTH(16), .DEPTH(RANGE_DEPTH)) u_rng (
      .clock, .wr_en(r_we), .wr_addr(req_ff.table_index),
      .wr_data(req_ff.weight_value), .rd_addr(r_raddr), .rd_data(r_rdata)
   );
   bfpq_div #(.NUM_W(SUM_W), .DEN_W(TOT_W)) u_div (
      .clock, .reset, .start(div_start), .numer(sum_ff), .denom(total_ff),
      .done(div_done), .quot(div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         width_ff <= 8'd128;
         height_ff <= 8'd128;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_WIDTH:  width_ff <= csr_wdata;
               CSR_HEIGHT: height_ff <= csr_wdata;
               default:    ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_data;
                  state_ff <= (req_data.opcode == OP_QUERY) ? S_CREAD : S_WRITE;
               end
            end
            S_WRITE: state_ff <= S_IDLE;
            S_CREAD: begin
               if (!ok_in) begin
                  rsp_ff <= '{filtered_pixel: 8'd0, status: 1'b1};
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_CWAIT;
               end
            end
            S_CWAIT: begin
               center_ff <= p_rdata;
               if (req_ff.coord_x == '0 || req_ff.coord_y == '0) begin
                  rsp_ff <= '{filtered_pixel: p_rdata, status: 1'b0};
                  state_ff <= S_RESP;
               end else begin
                  i_ff <= '0;
                  j_ff <= '0;
                  total_ff <= '0;
                  sum_ff <= '0;
                  state_ff <= S_NREAD;
               end
            end
            S_NREAD: begin
               skip_ff <= !nb_in;
               state_ff <= S_NWAIT;
            end
            S_NWAIT: begin
               pix_ff <= p_rdata;
               state_ff <= S_WREAD;
            end
            S_WREAD: state_ff <= S_MUL;
            S_MUL: begin
               prod_ff <= 32'(s_rdata) * 32'(r_rdata);
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (!skip_ff) begin
                  total_ff <= total_ff + TOT_W'(prod_ff[31:15]);
                  sum_ff <= sum_ff + SUM_W'(prod_ff[31:15]) * SUM_W'(pix_ff);
               end
               if (j_ff == WW'(WIN - 1)) begin
                  j_ff <= '0;
                  if (i_ff == WW'(WIN - 1)) begin
                     state_ff <= S_DIV;
                  end else begin
                     i_ff <= i_ff + WW'(1);
                     state_ff <= S_NREAD;
                  end
               end else begin
                  j_ff <= j_ff + WW'(1);
                  state_ff <= S_NREAD;
               end
            end
            S_DIV: begin
               if (sum_ff == '0 || total_ff == '0) begin
                  rsp_ff <= '{filtered_pixel: center_ff, status: 1'b0};
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_DIVWAIT;
               end
            end
            S_DIVWAIT: begin
               if (div_done) begin
                  rsp_ff <= '{filtered_pixel: div_q[7:0], status: 1'b0};
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               if (rsp_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready and response valid together");
   a_resp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ff.opcode == OP_QUERY)
      else $error("response for a write");
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.filtered_pixel == 8'd0)
      else $error("error response carries data");
`endif
endmodule
